### hdl/owr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// owr_pkg
// Types and constants shared by the 1-Wire slave ROM layer modules.
// ----------------------------------------------------------------------------
package owr_pkg;

    // bus event codes carried in s_tuser
    localparam logic [1:0] EV_RESET  = 2'd0;
    localparam logic [1:0] EV_RX_BIT = 2'd1;
    localparam logic [1:0] EV_READ   = 2'd2;

    // network layer command bytes
    localparam logic [7:0] CMD_READ_ROM   = 8'h33;
    localparam logic [7:0] CMD_SKIP_ROM   = 8'hCC;
    localparam logic [7:0] CMD_MATCH_ROM  = 8'h55;
    localparam logic [7:0] CMD_SEARCH_ROM = 8'hF0;

    // device layer command byte
    localparam logic [7:0] CMD_WRITE_PAD  = 8'h4E;

    // widths of the packed ports
    localparam int unsigned ID_W       = 64;
    localparam int unsigned S_DATA_W   = 8;
    localparam int unsigned M_DATA_W   = 24;

    // link layer state
    typedef enum logic [3:0] {
        LINK_COMMAND   = 4'b0001,
        LINK_SEARCH    = 4'b0010,
        LINK_MATCH     = 4'b0100,
        LINK_ADDRESSED = 4'b1000
    } owr_link_t;

    // device layer mode
    typedef enum logic [1:0] {
        DEV_COMMAND   = 2'b01,
        DEV_PAD_WRITE = 2'b10
    } owr_dev_t;

    // one bus event
    typedef struct packed {
        logic [1:0] cmd;
        logic       rx_bit;
    } owr_item_t;

    // one result
    typedef struct packed {
        logic [1:0] write_slots;
        logic       drive_level;
        logic       pad_write;
        logic [7:0] pad_index;
        logic [7:0] pad_data;
    } owr_result_t;

endpackage : owr_pkg
`default_nettype wire

### hdl/owr_in_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// owr_in_stage
// Input register: holds one bus event until the engine consumes it.
// ----------------------------------------------------------------------------
module owr_in_stage
    import owr_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      load,
    input  wire logic      consume,
    input  wire owr_item_t item_in,
    output logic           valid,
    output owr_item_t      item_out
);

    logic      valid_reg, valid_next;
    owr_item_t item_reg;

    // occupancy of the stage
    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (consume) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // payload, no reset needed
    always_ff @(posedge aclk) begin
        if (load) begin
            item_reg <= item_in;
        end
    end

    assign valid    = valid_reg;
    assign item_out = item_reg;

endmodule : owr_in_stage
`default_nettype wire

### hdl/owr_engine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// owr_engine
// Link and device layer state with the single-pass next-state logic. The
// state moves on when step is high; result is the item's outcome.
// ----------------------------------------------------------------------------
module owr_engine
    import owr_pkg::*;
#(
    parameter int unsigned ROM_BITS = 64
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_we,
    input  wire logic [ID_W-1:0]   cfg_wdata,
    input  wire logic              step,
    input  wire owr_item_t         item,
    output owr_result_t            result
);

    localparam logic [6:0] RomEnd = 7'(ROM_BITS);

    logic [ID_W-1:0] rom_id_reg;
    owr_link_t       link_reg, link_next;
    owr_dev_t        dev_reg, dev_next;
    logic [5:0]      bit_index_reg, bit_index_next;
    logic [7:0]      shift_reg, shift_next;
    logic            selected_reg, selected_next;
    logic            search_bit_reg, search_bit_next;
    logic [7:0]      pad_ptr_reg, pad_ptr_next;

    logic [5:0]      gather_idx;
    logic [7:0]      gather_byte;
    logic            gather_done;
    logic [6:0]      rom_idx;
    logic            rom_done;
    logic            sel_after;
    logic            id_next_bit;

    // byte gathering and rom bit counting
    always_comb begin
        gather_idx  = bit_index_reg + 6'd1;
        gather_byte = {item.rx_bit, shift_reg[7:1]};
        gather_done = (gather_idx >= 6'd8);
        rom_idx     = {1'b0, bit_index_reg} + 7'd1;
        rom_done    = (rom_idx >= RomEnd);
        id_next_bit = rom_id_reg[rom_idx[5:0]];
    end

    // next state and result
    always_comb begin
        link_next       = link_reg;
        dev_next        = dev_reg;
        bit_index_next  = bit_index_reg;
        shift_next      = shift_reg;
        selected_next   = selected_reg;
        search_bit_next = search_bit_reg;
        pad_ptr_next    = pad_ptr_reg;
        sel_after       = selected_reg;
        result          = '0;
        result.drive_level = 1'b1;

        unique case (item.cmd)
            EV_RESET: begin
                link_next      = LINK_COMMAND;
                dev_next       = DEV_COMMAND;
                bit_index_next = '0;
                shift_next     = '0;
                selected_next  = 1'b0;
                pad_ptr_next   = '0;
            end
            EV_RX_BIT: begin
                unique case (link_reg)
                    LINK_COMMAND: begin
                        shift_next     = gather_byte;
                        bit_index_next = gather_done ? 6'd0 : gather_idx;
                        if (gather_done) begin
                            priority if (gather_byte == CMD_SKIP_ROM) begin
                                link_next = LINK_ADDRESSED;
                            end else if (gather_byte == CMD_MATCH_ROM) begin
                                selected_next = 1'b1;
                                link_next     = LINK_MATCH;
                            end else if (gather_byte == CMD_SEARCH_ROM) begin
                                // first pair offered is id bit 0
                                selected_next   = 1'b1;
                                search_bit_next = rom_id_reg[0];
                                shift_next      = rom_id_reg[0] ? 8'd1 : 8'd2;
                                link_next       = LINK_SEARCH;
                                result.write_slots = 2'd2;
                            end else begin
                                // read rom and unknown bytes: gather again
                                shift_next = gather_byte;
                            end
                        end
                    end
                    LINK_ADDRESSED: begin
                        shift_next     = gather_byte;
                        bit_index_next = gather_done ? 6'd0 : gather_idx;
                        if (gather_done) begin
                            if (dev_reg == DEV_PAD_WRITE) begin
                                result.pad_write = 1'b1;
                                result.pad_index = pad_ptr_reg;
                                result.pad_data  = gather_byte;
                                pad_ptr_next     = pad_ptr_reg + 8'd1;
                            end else if (gather_byte == CMD_WRITE_PAD) begin
                                dev_next = DEV_PAD_WRITE;
                            end
                        end
                    end
                    LINK_MATCH: begin
                        sel_after      = selected_reg &
                                         (rom_id_reg[bit_index_reg] == item.rx_bit);
                        selected_next  = sel_after;
                        bit_index_next = rom_done ? 6'd0 : rom_idx[5:0];
                        if (rom_done) begin
                            link_next = sel_after ? LINK_ADDRESSED : LINK_COMMAND;
                        end
                    end
                    default: begin
                        // search: compare the master's direction bit
                        sel_after      = selected_reg & (search_bit_reg == item.rx_bit);
                        selected_next  = sel_after;
                        bit_index_next = rom_done ? 6'd0 : rom_idx[5:0];
                        if (rom_done) begin
                            link_next = sel_after ? LINK_ADDRESSED : LINK_COMMAND;
                        end else begin
                            result.write_slots = 2'd2;
                            if (sel_after) begin
                                search_bit_next = id_next_bit;
                                shift_next      = id_next_bit ? 8'd1 : 8'd2;
                            end else begin
                                // deselected: release the line for both slots
                                shift_next = 8'd3;
                            end
                        end
                    end
                endcase
            end
            EV_READ: begin
                if (link_reg == LINK_ADDRESSED) begin
                    result.drive_level = 1'b0;
                end else begin
                    result.drive_level = shift_reg[0];
                    shift_next         = {1'b0, shift_reg[7:1]};
                end
            end
            default: begin
                // unused event code: idle result
            end
        endcase
    end

    // identity register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rom_id_reg <= '0;
        end else if (cfg_we) begin
            rom_id_reg <= cfg_wdata;
        end
    end

    // layer state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            link_reg       <= LINK_COMMAND;
            dev_reg        <= DEV_COMMAND;
            bit_index_reg  <= '0;
            shift_reg      <= '0;
            selected_reg   <= 1'b0;
            search_bit_reg <= 1'b0;
            pad_ptr_reg    <= '0;
        end else if (step) begin
            link_reg       <= link_next;
            dev_reg        <= dev_next;
            bit_index_reg  <= bit_index_next;
            shift_reg      <= shift_next;
            selected_reg   <= selected_next;
            search_bit_reg <= search_bit_next;
            pad_ptr_reg    <= pad_ptr_next;
        end
    end

endmodule : owr_engine
`default_nettype wire

### hdl/owr_out_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// owr_out_stage
// Result register: holds one result until the receiver takes it.
// ----------------------------------------------------------------------------
module owr_out_stage
    import owr_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        load,
    input  wire logic        taken,
    input  wire owr_result_t result_in,
    output logic             valid,
    output owr_result_t      result_out
);

    logic        valid_reg, valid_next;
    owr_result_t result_reg;

    // occupancy of the stage
    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (taken) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // payload, no reset needed
    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= result_in;
        end
    end

    assign valid      = valid_reg;
    assign result_out = result_reg;

endmodule : owr_out_stage
`default_nettype wire

### hdl/onewire_slave_rom_layer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// onewire_slave_rom_layer
// Network (ROM) layer of a 1-Wire slave with a small scratchpad device layer.
//
// Input channel s_*: one bus event per item (bus reset, received bit or
// master read slot); s_tuser carries the event code, s_tdata[0] the bit.
// Output channel m_*: exactly one result per event: read slots to drive next,
// line level for a read slot, and an optional scratchpad byte write.
// cfg_we/cfg_wdata load the 64-bit ROM identity; write only while idle.
//
// m_tvalid rises after the item is accepted: the accepting edge loads the
// input register, and a later step applies the state update and loads the
// result register. Throughput is one item per cycle while the receiver
// takes each result; a stall on m_tready holds the flow.
// When the receiver stalls, the result register holds and the input register
// still takes one more item; s_tready falls only once both are full.
// Reset (aresetn low, synchronous) empties both registers, clears the
// identity and puts the link and device layers in command mode.
// ----------------------------------------------------------------------------
module onewire_slave_rom_layer
    import owr_pkg::*;
#(
    parameter int unsigned ROM_BITS = 64
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // configuration
    input  wire logic                  cfg_we,
    input  wire logic [ID_W-1:0]       cfg_wdata,
    // input items
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [S_DATA_W-1:0]   s_tdata,   // [0] rx_bit, [7:1] zero
    input  wire logic [1:0]            s_tuser,   // [1:0] cmd
    // result items
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [M_DATA_W-1:0]        m_tdata,   // [1:0] write_slots, [2] drive_level,
                                                  // [10:3] pad_index, [18:11] pad_data,
                                                  // [23:19] zero
    output logic [0:0]                 m_tuser    // [0] pad_write
);

    logic        in_valid;
    logic        out_valid;
    logic        step;
    logic        s_accept;
    owr_item_t   s_item;
    owr_item_t   cur_item;
    owr_result_t cur_result;
    owr_result_t out_result;

    // pipeline handshake
    assign step     = in_valid & (~out_valid | m_tready);
    assign s_tready = ~in_valid | step;
    assign s_accept = s_tvalid & s_tready;

    assign s_item.cmd    = s_tuser;
    assign s_item.rx_bit = s_tdata[0];

    owr_in_stage u_in (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (s_accept),
        .consume  (step),
        .item_in  (s_item),
        .valid    (in_valid),
        .item_out (cur_item)
    );

    owr_engine #(
        .ROM_BITS (ROM_BITS)
    ) u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .step      (step),
        .item      (cur_item),
        .result    (cur_result)
    );

    owr_out_stage u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (step),
        .taken      (m_tready),
        .result_in  (cur_result),
        .valid      (out_valid),
        .result_out (out_result)
    );

    // result packing
    assign m_tvalid   = out_valid;
    assign m_tdata    = {5'd0, out_result.pad_data, out_result.pad_index,
                         out_result.drive_level, out_result.write_slots};
    assign m_tuser[0] = out_result.pad_write;

`ifndef SYNTHESIS
    // a stalled input side means both registers are occupied
    a_stall_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (in_valid && out_valid))
        else $error("s_tready low with a free stage");

    // a new result only appears after the engine stepped
    a_result_from_step: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(step))
        else $error("result appeared without a step");

    // a scratchpad write never drives slots or the line
    a_pad_write_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata[1:0] == 2'd0 && m_tdata[2]))
        else $error("pad write combined with slot or line activity");

    // a result held by the receiver is not overwritten
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid && !m_tready) |-> !step)
        else $error("result register overwritten while stalled");
`endif

endmodule : onewire_slave_rom_layer
`default_nettype wire

### verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the 1-Wire slave ROM layer. A queue of bus events
// (resets, received bits, read slots) feeds a clocked stream driver; each
// accepted item runs through a bit-exact model of the link and device layers
// and the predicted response is queued. A clocked monitor compares every
// result item with the oldest prediction. Phases change the ROM identity,
// the idling pattern on both sides and, once, hold off the receiver for a
// long stretch so that the block fills up and stalls its input.
// ----------------------------------------------------------------------------
module tb
    import owr_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned ROM_BITS   = 64;
    localparam logic [1:0]  EV_UNUSED  = 2'd3;
    localparam int          HOLD_LEN   = 400;
    localparam int          STALL_MAX  = 5000;
    localparam int          SETTLE     = 6;
    localparam int          REPORT_MAX = 10;

    typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                cfg_we    = 1'b0;
    logic [ID_W-1:0]     cfg_wdata = '0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata   = '0;
    logic [1:0]          s_tuser   = '0;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic [0:0]          m_tuser;

    owr_item_t   pending_events[$];
    owr_result_t pending_responses[$];

    idle_mode_t idle_mode   = IDLE_NONE;
    bit         pressure_on = 1'b0;
    int         fail_count  = 0;
    int         hold_left   = 0;
    bit         hold_taken  = 1'b0;
    int         quiet_count = 0;

    // mirrored state of the link and device layers
    logic [63:0] id_model;
    owr_link_t   link_now;
    owr_dev_t    dev_now;
    logic [5:0]  bit_cnt;
    logic [7:0]  shift_now;
    logic        selected;
    logic        offered_bit;
    logic [7:0]  pad_ptr;

    onewire_slave_rom_layer #(
        .ROM_BITS(ROM_BITS)
    ) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // clock
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // response model
    // ------------------------------------------------------------------------

    // shift one bit in lsb first, true once a byte is complete
    function automatic bit shift_in(logic b);
        shift_now = {b, shift_now[7:1]};
        bit_cnt   = bit_cnt + 6'd1;
        if (bit_cnt >= 6'd8) begin
            bit_cnt = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // step the rom bit counter, true when the rom phase is over
    function automatic bit rom_step();
        logic [6:0] nxt;
        nxt = {1'b0, bit_cnt} + 7'd1;
        if (nxt >= 7'(ROM_BITS)) begin
            bit_cnt  = '0;
            link_now = selected ? LINK_ADDRESSED : LINK_COMMAND;
            return 1'b1;
        end
        bit_cnt = nxt[5:0];
        return 1'b0;
    endfunction

    // load the id bit and its complement for the next two read slots, or ones for both when deselected
    function automatic void load_pair();
        if (selected) begin
            offered_bit = id_model[bit_cnt];
            shift_now   = offered_bit ? 8'd1 : 8'd2;
        end else begin
            shift_now = 8'd3;
        end
    endfunction

    function automatic owr_result_t bus_event_response(logic [1:0] ev, logic b);
        owr_result_t r;
        r = '0;
        r.drive_level = 1'b1;
        case (ev)
            EV_RESET: begin
                link_now  = LINK_COMMAND;
                dev_now   = DEV_COMMAND;
                bit_cnt   = '0;
                shift_now = '0;
                selected  = 1'b0;
                pad_ptr   = '0;
            end
            EV_RX_BIT: begin
                case (link_now)
                    LINK_COMMAND: begin
                        if (shift_in(b)) begin
                            if (shift_now == CMD_SKIP_ROM) begin
                                link_now = LINK_ADDRESSED;
                            end else if (shift_now == CMD_MATCH_ROM) begin
                                bit_cnt  = '0;
                                selected = 1'b1;
                                link_now = LINK_MATCH;
                            end else if (shift_now == CMD_SEARCH_ROM) begin
                                bit_cnt  = '0;
                                selected = 1'b1;
                                load_pair();
                                link_now = LINK_SEARCH;
                                r.write_slots = 2'd2;
                            end
                        end
                    end
                    LINK_ADDRESSED: begin
                        if (shift_in(b)) begin
                            if (dev_now == DEV_COMMAND) begin
                                if (shift_now == CMD_WRITE_PAD)
                                    dev_now = DEV_PAD_WRITE;
                            end else begin
                                r.pad_write = 1'b1;
                                r.pad_index = pad_ptr;
                                r.pad_data  = shift_now;
                                pad_ptr     = pad_ptr + 8'd1;
                            end
                        end
                    end
                    LINK_MATCH: begin
                        if (id_model[bit_cnt] != b)
                            selected = 1'b0;
                        void'(rom_step());
                    end
                    default: begin
                        if (offered_bit != b)
                            selected = 1'b0;
                        if (!rom_step()) begin
                            load_pair();
                            r.write_slots = 2'd2;
                        end
                    end
                endcase
            end
            EV_READ: begin
                // addressed: the device layer has nothing to send
                if (link_now == LINK_ADDRESSED) begin
                    r.drive_level = 1'b0;
                end else begin
                    r.drive_level = shift_now[0];
                    shift_now     = shift_now >> 1;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    task automatic push_ev(logic [1:0] ev, logic b);
        owr_item_t it;
        it.cmd    = ev;
        it.rx_bit = b;
        pending_events.push_back(it);
    endtask

    task automatic push_byte(logic [7:0] val);
        for (int i = 0; i < 8; i++)
            push_ev(EV_RX_BIT, val[i]);
    endtask

    task automatic add_noise(int n);
        int pick;
        repeat (n) begin
            pick = $urandom_range(9);
            if (pick == 0)
                push_ev(EV_RESET, 1'($urandom_range(1)));
            else if (pick == 1)
                push_ev(EV_UNUSED, 1'($urandom_range(1)));
            else if (pick < 7)
                push_ev(EV_RX_BIT, 1'($urandom_range(1)));
            else
                push_ev(EV_READ, 1'($urandom_range(1)));
        end
    endtask

    // device command then a few bytes, with the odd read slot in between
    task automatic device_traffic();
        int n;
        n = $urandom_range(1, 10);
        push_byte(($urandom_range(3) != 0) ? CMD_WRITE_PAD : 8'($urandom));
        repeat (n) begin
            if ($urandom_range(5) == 0)
                push_ev(EV_READ, 1'($urandom_range(1)));
            push_byte(8'($urandom));
        end
    endtask

    task automatic match_seq(logic [63:0] id);
        int flip;
        int cut;
        flip = ($urandom_range(3) == 0) ? int'($urandom_range(63)) : -1;
        cut  = ($urandom_range(7) == 0) ? int'($urandom_range(63)) : 64;
        push_ev(EV_RESET, 1'($urandom_range(1)));
        push_byte(CMD_MATCH_ROM);
        for (int i = 0; i < cut; i++)
            push_ev(EV_RX_BIT, id[i] ^ (i == flip));
        if (cut < 64)
            add_noise($urandom_range(1, 6));
        else
            device_traffic();
    endtask

    task automatic search_seq(logic [63:0] id);
        int flip;
        int cut;
        flip = ($urandom_range(2) == 0) ? int'($urandom_range(63)) : -1;
        cut  = ($urandom_range(7) == 0) ? int'($urandom_range(63)) : 64;
        push_ev(EV_RESET, 1'($urandom_range(1)));
        push_byte(CMD_SEARCH_ROM);
        for (int i = 0; i < cut; i++) begin
            push_ev(EV_READ, 1'($urandom_range(1)));
            push_ev(EV_READ, 1'($urandom_range(1)));
            push_ev(EV_RX_BIT, id[i] ^ (i == flip));
        end
        if (cut < 64)
            add_noise($urandom_range(1, 6));
        else
            device_traffic();
    endtask

    task automatic skip_seq(int n);
        push_ev(EV_RESET, 1'($urandom_range(1)));
        push_byte(CMD_SKIP_ROM);
        push_byte(CMD_WRITE_PAD);
        push_byte(8'h00);
        push_byte(8'hFF);
        repeat (n) begin
            if ($urandom_range(7) == 0)
                push_ev(EV_READ, 1'($urandom_range(1)));
            push_byte(8'($urandom));
        end
    endtask

    // mostly well-formed transactions, the rest noise and odd commands
    task automatic random_traffic(logic [63:0] id, int target);
        int pick;
        while (pending_events.size() < target) begin
            pick = $urandom_range(99);
            if (pick < 30) begin
                search_seq(id);
            end else if (pick < 55) begin
                match_seq(id);
            end else if (pick < 70) begin
                push_ev(EV_RESET, 1'($urandom_range(1)));
                push_byte(CMD_SKIP_ROM);
                device_traffic();
            end else if (pick < 80) begin
                push_ev(EV_RESET, 1'($urandom_range(1)));
                push_byte(($urandom_range(1) != 0) ? CMD_READ_ROM : 8'($urandom));
                add_noise($urandom_range(1, 12));
            end else begin
                add_noise($urandom_range(4, 30));
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // phase control
    // ------------------------------------------------------------------------

    task automatic load_rom_id(logic [63:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        id_model   = val;
        @(negedge aclk);
    endtask

    task automatic drain();
        while (pending_events.size() != 0 || s_tvalid || pending_responses.size() != 0)
            @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    task automatic run_phase(logic [63:0] id, idle_mode_t mode, bit press,
                             int long_pad, int target);
        load_rom_id(id);
        idle_mode   = mode;
        pressure_on = press;
        if (long_pad > 0)
            skip_seq(long_pad);
        random_traffic(id, target);
        drain();
        pressure_on = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // driver: next event item goes out once the slot is free
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        owr_item_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                pending_responses.push_back(bus_event_response(s_tuser, s_tdata[0]));
            if (!s_tvalid || s_tready) begin
                if (pending_events.size() != 0 &&
                    !((idle_mode == IDLE_SEND && $urandom_range(99) < 57) ||
                      (idle_mode == IDLE_BOTH && $urandom_range(99) < 36))) begin
                    nxt      = pending_events.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= nxt.cmd;
                    s_tdata  <= {7'b0, nxt.rx_bit};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // monitor: check result items, drive the receiver side
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        owr_result_t got;
        owr_result_t want;
        if (!aresetn) begin
            m_tready   <= 1'b0;
            hold_left  <= 0;
            hold_taken <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.write_slots = m_tdata[1:0];
                got.drive_level = m_tdata[2];
                got.pad_write   = m_tuser[0];
                got.pad_index   = m_tdata[10:3];
                got.pad_data    = m_tdata[18:11];
                if (pending_responses.size() == 0) begin
                    fail_count++;
                    if (fail_count <= REPORT_MAX)
                        $display("unexpected result item: tdata=%06h tuser=%0b",
                                 m_tdata, m_tuser);
                end else begin
                    want = pending_responses.pop_front();
                    if (got !== want || m_tdata[23:19] !== 5'b0) begin
                        fail_count++;
                        if (fail_count <= REPORT_MAX)
                            $display({"mismatch: expected slots=%0d level=%0b wr=%0b ",
                                      "idx=%02h data=%02h, got slots=%0d level=%0b ",
                                      "wr=%0b idx=%02h data=%02h pad=%02h"},
                                     want.write_slots, want.drive_level, want.pad_write,
                                     want.pad_index, want.pad_data,
                                     got.write_slots, got.drive_level, got.pad_write,
                                     got.pad_index, got.pad_data, m_tdata[23:19]);
                    end
                end
            end
            // long hold-off once per pressure phase, random stalls otherwise
            if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                m_tready  <= 1'b0;
            end else if (pressure_on && !hold_taken) begin
                hold_left  <= HOLD_LEN;
                hold_taken <= 1'b1;
                m_tready   <= 1'b0;
            end else begin
                if (!pressure_on)
                    hold_taken <= 1'b0;
                m_tready <= !((idle_mode == IDLE_RECV && $urandom_range(99) < 57) ||
                              (idle_mode == IDLE_BOTH && $urandom_range(99) < 36));
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_count <= 0;
        else
            quiet_count <= quiet_count + 1;
        if (quiet_count >= STALL_MAX) begin
            $display("watchdog: no progress for %0d cycles", quiet_count);
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        id_model    = '0;
        link_now    = LINK_COMMAND;
        dev_now     = DEV_COMMAND;
        bit_cnt     = '0;
        shift_now   = '0;
        selected    = 1'b0;
        offered_bit = 1'b0;
        pad_ptr     = '0;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        load_rom_id(64'h0);

        // directed: unused code, read slot before any command, skip rom,
        // pad write entry, read slot while addressed, one full byte
        idle_mode = IDLE_NONE;
        push_ev(EV_RESET, 1'b1);
        push_ev(EV_UNUSED, 1'b1);
        push_ev(EV_READ, 1'b0);
        push_byte(CMD_SKIP_ROM);
        push_byte(CMD_WRITE_PAD);
        push_ev(EV_READ, 1'b1);
        push_byte(8'hFF);
        drain();

        run_phase(64'hFFFF_FFFF_FFFF_FFFF, IDLE_NONE, 1'b0, 0, 220);
        run_phase({$urandom, $urandom}, IDLE_SEND, 1'b0, 0, 220);
        run_phase(64'hAAAA_AAAA_AAAA_AAAA, IDLE_RECV, 1'b0, 0, 220);
        run_phase({$urandom, $urandom}, IDLE_BOTH, 1'b0, 0, 220);
        // pressure phase opening with a long scratchpad run
        run_phase(64'h5555_5555_5555_5555, IDLE_NONE, 1'b1, 40, 400);
        run_phase(64'h0, IDLE_BOTH, 1'b0, 0, 100);

        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule : tb

### filelist.f
hdl/owr_pkg.sv
hdl/owr_in_stage.sv
hdl/owr_engine.sv
hdl/owr_out_stage.sv
hdl/onewire_slave_rom_layer.sv
verif/tb.sv
